>>> rtl/sle_pkg.sv
// Shared types and constants of the sequential list engine.
`default_nettype none

package sle_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 8;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_GET    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_ISSUE = 2'd1,
        S_TAIL  = 2'd2,
        S_FIN   = 2'd3
    } state_t;

endpackage

`default_nettype wire

>>> rtl/sle_if.sv
// Request and response channel interfaces of the sequential list engine.
`default_nettype none

interface sle_req_if
    import sle_pkg::*;
();
    logic                      valid;
    logic                      ready;
    action_t                   action;
    logic        [POS_W-1:0]   position;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface sle_rsp_if
    import sle_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      success;
    logic signed [DATA_W-1:0]  item_value;
    logic signed [POS_W-1:0]   found_index;
    logic        [COUNT_W-1:0] count;

    modport source (output valid, output success, output item_value, output found_index,
                    output count, input ready);
    modport sink   (input valid, input success, input item_value, input found_index,
                    input count, output ready);
endinterface

`default_nettype wire

>>> rtl/sequential_list_engine_core.sv
// Top level of the sequential list engine: array list with insert, delete, find and get.
//
//  port | dir | beat contents
//  -----+-----+-------------------------------------------------
//  req  | in  | action, position, value
//  rsp  | out | success, item_value, found_index, count
//
// One request at a time; the entry memory read port sets the pace, one entry per cycle.
// Insert before the end, delete, get and find on a non-empty list step through ISSUE (one
// read per entry), TAIL and FIN; a rejected request, insert at the end or find on an empty
// list go straight from IDLE to FIN.
// Reset clears the length to zero; entries stay unknown until written.
// req.ready is high only between requests; a held response stalls the final step.
`default_nettype none

module sequential_list_engine_core
    import sle_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input wire logic clk,
    input wire logic rst_n,
    sle_req_if.sink  req,
    sle_rsp_if.source rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    state_t             state_reg, state_next;
    action_t            act_reg, act_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      end_reg, end_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic               ok_reg, ok_next;
    logic               rdv_reg, rdv_next;
    logic [AW-1:0]      rda_reg, rda_next;
    logic [DATA_W-1:0]  item_reg, item_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      fidx_reg, fidx_next;

    logic               ov_reg, ov_next;
    logic               osucc_reg, osucc_next;
    logic [DATA_W-1:0]  oitem_reg, oitem_next;
    logic [POS_W-1:0]   ofidx_reg, ofidx_next;
    logic [COUNT_W-1:0] ocnt_reg, ocnt_next;

    logic               we, re;
    logic [AW-1:0]      waddr, raddr;
    logic [DATA_W-1:0]  wdata, rd_q;
    logic [CW-1:0]      pos_ext, len_ext;
    logic               slot_free, load;
    logic [AW+7:0]      fidx_wide;
    logic [LW+7:0]      cnt_wide;

    sle_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DATA_W)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_q)
    );

    assign pos_ext   = CW'(req.position);
    assign len_ext   = CW'(len_reg);
    assign slot_free = !ov_reg || rsp.ready;
    assign load      = (state_reg == S_FIN) && slot_free;
    assign re        = (state_reg == S_ISSUE);
    assign raddr     = ptr_reg;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        we    = 1'b0;
        waddr = rda_reg;
        wdata = rd_q;
        if (rdv_reg)
        begin
            if (act_reg == ACT_INSERT)
            begin
                we    = 1'b1;
                waddr = rda_reg + AW'(1);
            end
            else if (act_reg == ACT_DELETE && rda_reg != pos_reg)
            begin
                we    = 1'b1;
                waddr = rda_reg - AW'(1);
            end
        end
        else if (load && ok_reg && act_reg == ACT_INSERT)
        begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = val_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        ok_next    = ok_reg;
        rdv_next   = re;
        rda_next   = ptr_reg;
        item_next  = item_reg;
        found_next = found_reg;
        fidx_next  = fidx_reg;
        ov_next    = ov_reg && !rsp.ready;
        osucc_next = osucc_reg;
        oitem_next = oitem_reg;
        ofidx_next = ofidx_reg;
        ocnt_next  = ocnt_reg;
        fidx_wide  = {8'd0, fidx_reg};
        cnt_wide   = {8'd0, len_reg};

        if (rdv_reg)
        begin
            unique case (act_reg)
                ACT_GET:
                begin
                    item_next = rd_q;
                end
                ACT_DELETE:
                begin
                    if (rda_reg == pos_reg)
                    begin
                        item_next = rd_q;
                    end
                end
                ACT_FIND:
                begin
                    if (!found_reg && rd_q == val_reg)
                    begin
                        found_next = 1'b1;
                        fidx_next  = rda_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next   = req.action;
                    pos_next   = pos_ext[AW-1:0];
                    val_next   = req.value;
                    item_next  = '0;
                    found_next = 1'b0;
                    fidx_next  = '0;
                    state_next = S_FIN;
                    unique case (req.action)
                        ACT_INSERT:
                        begin
                            ok_next = (pos_ext <= len_ext) && (len_ext < CW'(CAPACITY));
                            if (ok_next && pos_ext < len_ext)
                            begin
                                ptr_next   = AW'(len_reg - LW'(1));
                                end_next   = pos_ext[AW-1:0];
                                state_next = S_ISSUE;
                            end
                        end
                        ACT_DELETE:
                        begin
                            ok_next = pos_ext < len_ext;
                            if (ok_next)
                            begin
                                ptr_next   = pos_ext[AW-1:0];
                                end_next   = AW'(len_reg - LW'(1));
                                state_next = S_ISSUE;
                            end
                        end
                        ACT_FIND:
                        begin
                            ok_next = 1'b1;
                            if (len_reg != '0)
                            begin
                                ptr_next   = '0;
                                end_next   = AW'(len_reg - LW'(1));
                                state_next = S_ISSUE;
                            end
                        end
                        ACT_GET:
                        begin
                            ok_next = pos_ext < len_ext;
                            if (ok_next)
                            begin
                                ptr_next   = pos_ext[AW-1:0];
                                end_next   = pos_ext[AW-1:0];
                                state_next = S_ISSUE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                if (ptr_reg == end_reg)
                begin
                    state_next = S_TAIL;
                end
                else if (act_reg == ACT_INSERT)
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_TAIL:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    if (ok_reg && act_reg == ACT_INSERT)
                    begin
                        len_next = len_reg + LW'(1);
                    end
                    else if (ok_reg && act_reg == ACT_DELETE)
                    begin
                        len_next = len_reg - LW'(1);
                    end
                    cnt_wide   = {8'd0, len_next};
                    ov_next    = 1'b1;
                    osucc_next = ok_reg;
                    oitem_next = item_reg;
                    ofidx_next = '0;
                    if (act_reg == ACT_FIND)
                    begin
                        ofidx_next = found_reg ? fidx_wide[7:0] : '1;
                    end
                    ocnt_next  = cnt_wide[7:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            rdv_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            rdv_reg   <= rdv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        ptr_reg   <= ptr_next;
        end_reg   <= end_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        ok_reg    <= ok_next;
        rda_reg   <= rda_next;
        item_reg  <= item_next;
        found_reg <= found_next;
        fidx_reg  <= fidx_next;
        osucc_reg <= osucc_next;
        oitem_reg <= oitem_next;
        ofidx_reg <= ofidx_next;
        ocnt_reg  <= ocnt_next;
    end

    assign rsp.valid       = ov_reg;
    assign rsp.success     = osucc_reg;
    assign rsp.item_value  = oitem_reg;
    assign rsp.found_index = ofidx_reg;
    assign rsp.count       = ocnt_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(CAPACITY))
        else $error("list length above capacity");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (we && re) |-> (waddr != raddr))
        else $error("write and read of the same entry in one cycle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    a_fail_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !ok_reg) |=> $stable(len_reg))
        else $error("rejected request changed the length");

endmodule

`default_nettype wire

>>> rtl/sle_mem.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module sle_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
